// ===== src/rcmr_pkg.sv =====
// Package for the rod cutting max revenue core: sizes, state encoding.
// No dependencies; used by rod_cutting_max_revenue_core.
package rcmr_pkg;

  localparam int MAX_LEN   = 256;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int PRICE_W   = 16;
  localparam int REV_W     = 24;
  localparam int SUM_W     = REV_W + 1;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [REV_W-1:0]   rev_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

// ===== src/rod_cutting_max_revenue_core.sv =====
// Rod cutting best-revenue core: price memory, best-revenue memory, fill sequencer.
// Depends on rcmr_pkg.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+------------------------------
//   in      | in_valid_i  | in_stall_o   | piece_price_i, last_price_i
//   out     | out_valid_o | out_stall_i  | max_revenue_o
//
// Price beats are stored while loading. The flagged beat starts the table fill:
// each length L reads one candidate per piece through the single read
// port of each memory, then writes best[L]; after the last length the
// result is handed over to the output.
// Input stalls during the fill and while the result waits for a free output slot.
// Reset clears control only; both memories need no clearing.
module rod_cutting_max_revenue_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rcmr_pkg::PRICE_W-1:0] piece_price_i,
  input  logic                         last_price_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rcmr_pkg::REV_W-1:0]   max_revenue_o
);

  rcmr_pkg::price_t price_mem [rcmr_pkg::MAX_LEN];
  rcmr_pkg::rev_t   best_mem  [rcmr_pkg::MAX_LEN + 1];

  rcmr_pkg::state_e state_q, state_d;
  rcmr_pkg::cnt_t   cnt_q, cnt_d;
  rcmr_pkg::cnt_t   n_q, n_d;
  rcmr_pkg::cnt_t   len_q, len_d;
  rcmr_pkg::cnt_t   piece_q, piece_d;
  rcmr_pkg::rev_t   top_q, top_d;
  rcmr_pkg::rev_t   res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic             rd_valid_q, rd_valid_d;
  logic             rd_zero_q, rd_zero_d;
  rcmr_pkg::price_t price_rd_q;
  rcmr_pkg::rev_t   best_rd_q;

  logic             in_acc;
  logic             price_we;
  logic             best_we;
  rcmr_pkg::rev_t   best_wdata;
  rcmr_pkg::addr_t  price_raddr;
  rcmr_pkg::cnt_t   best_raddr;
  logic             rd_en;
  logic [rcmr_pkg::SUM_W-1:0] cand_sum;
  rcmr_pkg::rev_t   cand;
  rcmr_pkg::rev_t   top_new;

  assign in_stall_o    = (state_q != rcmr_pkg::ST_LOAD);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign max_revenue_o = res_q;

  assign price_raddr = rcmr_pkg::ADDR_W'(piece_q - rcmr_pkg::cnt_t'(1));
  assign best_raddr  = len_q - piece_q;

  // Candidate from the beat read last cycle; best[0] reads as zero.
  always_comb begin
    cand_sum = rcmr_pkg::SUM_W'(price_rd_q)
             + rcmr_pkg::SUM_W'(rd_zero_q ? '0 : best_rd_q);
    cand     = cand_sum[rcmr_pkg::SUM_W-1] ? '1 : cand_sum[rcmr_pkg::REV_W-1:0];
    top_new  = (rd_valid_q && (cand > top_q)) ? cand : top_q;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    len_d       = len_q;
    piece_d     = piece_q;
    top_d       = top_new;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    rd_valid_d  = 1'b0;
    rd_zero_d   = rd_zero_q;
    rd_en       = 1'b0;
    price_we    = 1'b0;
    best_we     = 1'b0;
    best_wdata  = top_new;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rcmr_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (cnt_q < rcmr_pkg::CNT_W'(rcmr_pkg::MAX_LEN)) begin
            price_we = 1'b1;
            cnt_d    = cnt_q + rcmr_pkg::cnt_t'(1);
          end
          if (last_price_i) begin
            n_d     = cnt_d;
            cnt_d   = '0;
            len_d   = rcmr_pkg::cnt_t'(1);
            piece_d = rcmr_pkg::cnt_t'(1);
            top_d   = '0;
            state_d = rcmr_pkg::ST_RUN;
          end
        end
      end
      rcmr_pkg::ST_RUN: begin
        rd_en      = 1'b1;
        rd_valid_d = 1'b1;
        rd_zero_d  = (best_raddr == '0);
        if (piece_q == len_q) begin
          state_d = rcmr_pkg::ST_DRAIN;
        end else begin
          piece_d = piece_q + rcmr_pkg::cnt_t'(1);
        end
      end
      rcmr_pkg::ST_DRAIN: begin
        // Last candidate lands now; commit best[len].
        best_we = 1'b1;
        if (len_q == n_q) begin
          // hold best[n] in top until the output slot frees up
          state_d = rcmr_pkg::ST_FINISH;
        end else begin
          top_d   = '0;
          len_d   = len_q + rcmr_pkg::cnt_t'(1);
          piece_d = rcmr_pkg::cnt_t'(1);
          state_d = rcmr_pkg::ST_RUN;
        end
      end
      rcmr_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          res_d       = top_q;
          out_valid_d = 1'b1;
          state_d     = rcmr_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = rcmr_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcmr_pkg::ST_LOAD;
      cnt_q       <= '0;
      n_q         <= '0;
      len_q       <= '0;
      piece_q     <= '0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      len_q       <= len_d;
      piece_q     <= piece_d;
      out_valid_q <= out_valid_d;
      rd_valid_q  <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    res_q     <= res_d;
    rd_zero_q <= rd_zero_d;
  end

  // Price memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (price_we) begin
      price_mem[cnt_q[rcmr_pkg::ADDR_W-1:0]] <= piece_price_i;
    end
    if (rd_en) begin
      price_rd_q <= price_mem[price_raddr];
    end
  end

  // Best-revenue memory: write of best[len] lands before the next length reads it.
  always_ff @(posedge clk_i) begin
    if (best_we) begin
      best_mem[len_q] <= best_wdata;
    end
    if (rd_en) begin
      best_rd_q <= best_mem[best_raddr];
    end
  end

  a_piece_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcmr_pkg::ST_RUN) |-> (piece_q != '0) && (piece_q <= len_q))
    else $error("piece index outside 1..len during fill");

  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcmr_pkg::ST_RUN || state_q == rcmr_pkg::ST_DRAIN)
      |-> (len_q != '0) && (len_q <= n_q))
    else $error("fill length outside 1..n");

  a_read_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(state_q) == rcmr_pkg::ST_RUN)
    else $error("read data valid without a read issued");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == rcmr_pkg::ST_FINISH)
    else $error("result raised outside the handover state");

endmodule

// ===== sim/rod_cutting_max_revenue_core_tb.sv =====
// Self-checking testbench for rod_cutting_max_revenue_core: price lists in, best revenue out.
// Depends on rcmr_pkg and the core (src/); a built-in solver predicts results unless a directed row gives its own.
module rod_cutting_max_revenue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD  = 4;
  localparam int unsigned REV_MAX     = (1 << rcmr_pkg::REV_W) - 1;
  localparam int          PHASE_BEATS = 600;
  localparam int          HOLD_AFTER  = 40;
  localparam int          HOLD_CYCLES = 3000;
  // a full 256-entry fill runs with nothing moving on either channel
  localparam int          QUIET_LIMIT = 200000;
  localparam int          DIR_ROWS    = 21;

  typedef enum int {PR_RANDOM, PR_SMALL, PR_LINEAR, PR_TOP, PR_ZERO} price_mix_e;

  typedef struct packed {
    rcmr_pkg::price_t price;
    logic             last;
    logic             typed;
    rcmr_pkg::rev_t   revenue;
  } dir_row_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  rcmr_pkg::price_t piece_price_i = '0;
  logic             last_price_i  = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  rcmr_pkg::rev_t   max_revenue_o;

  // solver state
  rcmr_pkg::price_t price_mem [rcmr_pkg::MAX_LEN];
  int unsigned      best_mem  [rcmr_pkg::MAX_LEN+1];
  rcmr_pkg::cnt_t   fill_count = '0;

  rcmr_pkg::rev_t revenue_q [$];
  rcmr_pkg::rev_t head_rev;
  int   mismatches        = 0;
  int   results_seen      = 0;
  int   hold_left         = 0;
  bit   held              = 1'b0;
  int   quiet_cycles      = 0;
  int   sender_idle_pct   = 24;
  int   receiver_idle_pct = 63;
  int   beats_sent        = 0;

  // single-piece and two-, three- and four-piece lists whose best cut is obvious
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{16'h0000, 1'b1, 1'b1, 24'h000000},
    '{16'hFFFF, 1'b1, 1'b1, 24'h00FFFF},
    '{16'h8000, 1'b0, 1'b0, 24'h000000},
    '{16'h0001, 1'b1, 1'b1, 24'h010000},
    '{16'hFFFF, 1'b0, 1'b0, 24'h000000},
    '{16'hFFFF, 1'b1, 1'b1, 24'h01FFFE},
    '{16'hAAAA, 1'b0, 1'b0, 24'h000000},
    '{16'h5555, 1'b1, 1'b1, 24'h015554},
    '{16'h0000, 1'b0, 1'b0, 24'h000000},
    '{16'h0000, 1'b0, 1'b0, 24'h000000},
    '{16'h0000, 1'b1, 1'b1, 24'h000000},
    '{16'h0005, 1'b0, 1'b0, 24'h000000},
    '{16'h0000, 1'b0, 1'b0, 24'h000000},
    '{16'h0000, 1'b0, 1'b0, 24'h000000},
    '{16'h0000, 1'b1, 1'b1, 24'h000014},
    '{16'h0001, 1'b0, 1'b0, 24'h000000},
    '{16'h0005, 1'b0, 1'b0, 24'h000000},
    '{16'h0008, 1'b0, 1'b0, 24'h000000},
    '{16'h0009, 1'b1, 1'b1, 24'h00000A},
    '{16'h1234, 1'b0, 1'b0, 24'h000000},
    '{16'hFEDC, 1'b1, 1'b0, 24'h000000}
  };

  rod_cutting_max_revenue_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .piece_price_i (piece_price_i),
    .last_price_i  (last_price_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .max_revenue_o (max_revenue_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Store one price; on the flagged entry solve the whole table and return best[n].
  function automatic bit solve_price(input rcmr_pkg::price_t price, input logic last,
                                     output rcmr_pkg::rev_t rev);
    int unsigned top;
    int unsigned cand;
    int          n;
    rev = '0;
    if (fill_count < rcmr_pkg::MAX_LEN) begin
      price_mem[fill_count[rcmr_pkg::ADDR_W-1:0]] = price;
      fill_count++;
    end
    if (!last) return 1'b0;
    n = fill_count;
    best_mem[0] = 0;
    for (int len = 1; len <= n; len++) begin
      top = 0;
      for (int piece = 1; piece <= len; piece++) begin
        cand = price_mem[piece-1] + best_mem[len-piece];
        if (cand > top) top = cand;
      end
      if (top > REV_MAX) top = REV_MAX;
      best_mem[len] = top;
    end
    rev = best_mem[n][rcmr_pkg::REV_W-1:0];
    fill_count = '0;
    return 1'b1;
  endfunction

  task automatic offer_beat(input rcmr_pkg::price_t price, input logic last,
                            input logic typed, input rcmr_pkg::rev_t typed_rev);
    bit             done;
    rcmr_pkg::rev_t rev;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    piece_price_i <= price;
    last_price_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    done = solve_price(price, last, rev);
    if (done) revenue_q.push_back(typed ? typed_rev : rev);
  endtask

  task automatic offer_list(input int len, input price_mix_e mix);
    rcmr_pkg::price_t price;
    for (int k = 0; k < len; k++) begin
      case (mix)
        PR_RANDOM: price = rcmr_pkg::price_t'($urandom);
        PR_SMALL:  price = rcmr_pkg::price_t'($urandom_range(15));
        PR_TOP:    price = '1;
        PR_ZERO:   price = '0;
        default:   price = rcmr_pkg::price_t'((k + 1) * 97 + $urandom_range(200));
      endcase
      offer_beat(price, k == len - 1, 1'b0, '0);
    end
  endtask

  initial begin
    int         pick;
    int         len;
    price_mix_e mix;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      offer_beat(dir_rows[r].price, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].revenue);
    end

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   <= (phase == 0) ? 24 : (phase == 1) ? 63 : 0;
      receiver_idle_pct <= (phase == 0) ? 63 : (phase == 1) ? 24 : 0;
      beats_sent = 0;
      // one full-length list per phase: top revenue, overflow, overflow by one
      case (phase)
        0:       offer_list(rcmr_pkg::MAX_LEN, PR_TOP);
        1:       offer_list(rcmr_pkg::MAX_LEN + 44, PR_RANDOM);
        default: offer_list(rcmr_pkg::MAX_LEN + 1, PR_SMALL);
      endcase
      while (beats_sent < PHASE_BEATS) begin
        pick = $urandom_range(99);
        len  = (pick < 70) ? $urandom_range(1, 8) :
               (pick < 95) ? $urandom_range(9, 32) : $urandom_range(33, 80);
        pick = $urandom_range(99);
        mix  = (pick < 50) ? PR_RANDOM : (pick < 75) ? PR_SMALL :
               (pick < 85) ? PR_LINEAR : (pick < 92) ? PR_TOP : PR_ZERO;
        offer_list(len, mix);
      end
    end

    in_valid_i <= 1'b0;
    while (revenue_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("** rod_cutting_max_revenue_core: PASSED **");
    else
      $display("** rod_cutting_max_revenue_core: FAILED **");
    $finish;
  end

  // result side: check each beat, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (revenue_q.size() == 0) begin
          $display("%0t: max_revenue expected none, got %0d", $time, max_revenue_o);
          mismatches++;
        end else begin
          head_rev = revenue_q.pop_front();
          if (max_revenue_o !== head_rev) begin
            $display("%0t: max_revenue expected %0d, got %0d", $time, head_rev, max_revenue_o);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!held && results_seen == HOLD_AFTER) begin
        // hold off long enough for the core to back up into its input
        held        <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("** rod_cutting_max_revenue_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
